// ===== rtl/core/usb_midi_packet_decoder_assert.svh =====
// assertion macros shared by the usb-midi packet decoder modules
// expects clk_i and rst_ni in the scope of each use
`ifndef USB_MIDI_PACKET_DECODER_ASSERT_SVH
`define USB_MIDI_PACKET_DECODER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define UMPD_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("umpd same-cycle check failed");

// next-cycle implication, disabled while in reset
`define UMPD_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("umpd next-cycle check failed");

`endif

// ===== rtl/core/umpd_pkg.sv =====
// shared types and constants of the usb-midi packet decoder
// no dependencies
`default_nettype none

package umpd_pkg;

  localparam int unsigned SYSEX_DEPTH_DEF = 64;

  localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
  localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;
  localparam logic [7:0] BYTE_REALTIME    = 8'hF8;
  localparam logic [3:0] CHAN_MASK        = 4'hF;
  localparam logic [7:0] DATA_MASK        = 8'h7F;

  // usb-midi code index values
  localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
  localparam logic [3:0] CIN_SYSEX_END1 = 4'h5;
  localparam logic [3:0] CIN_SYSEX_END2 = 4'h6;
  localparam logic [3:0] CIN_SYSEX_END3 = 4'h7;
  localparam logic [3:0] CIN_NOTE_OFF   = 4'h8;
  localparam logic [3:0] CIN_NOTE_ON    = 4'h9;
  localparam logic [3:0] CIN_CONTROL    = 4'hB;
  localparam logic [3:0] CIN_PROGRAM    = 4'hC;
  localparam logic [3:0] CIN_BEND       = 4'hE;
  localparam logic [3:0] CIN_SINGLE     = 4'hF;

  typedef enum logic [2:0] {
    KIND_ACTIVITY = 3'd0,
    KIND_NOTE_OFF = 3'd1,
    KIND_NOTE_ON  = 3'd2,
    KIND_CONTROL  = 3'd3,
    KIND_PROGRAM  = 3'd4,
    KIND_BEND     = 3'd5,
    KIND_REALTIME = 3'd6,
    KIND_SYSEX    = 3'd7
  } kind_e;

  typedef enum logic {
    LOAD_SINGLE = 1'b0,
    LOAD_SYSEX  = 1'b1
  } load_sel_e;

  // controller to datapath
  typedef struct packed {
    logic      capture;
    logic      begin_frame;
    logic      append;
    logic      close_frame;
    logic      rd_req;
    logic      load;
    load_sel_e load_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_sysex;
    logic closing;
    logic append_last;
    logic emit_ok;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/umpd_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module umpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/core/umpd_dp.sv =====
// datapath: packet capture, decode, sysex frame store and output register
// depends on umpd_pkg, umpd_ram and the assertion macro header
`default_nettype none
`include "usb_midi_packet_decoder_assert.svh"

module umpd_dp #(
  parameter int unsigned SYSEX_DEPTH = umpd_pkg::SYSEX_DEPTH_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire umpd_pkg::cmd_t cmd_i,
  output umpd_pkg::sts_t      sts_o,
  input  wire logic [3:0]     code_index_i,
  input  wire logic [7:0]     status_byte_i,
  input  wire logic [7:0]     data_one_i,
  input  wire logic [7:0]     data_two_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic      [2:0]     event_kind_o,
  output logic      [3:0]     channel_o,
  output logic      [6:0]     first_value_o,
  output logic      [6:0]     second_value_o,
  output logic      [13:0]    bend_amount_o,
  output logic      [7:0]     realtime_byte_o,
  output logic      [7:0]     sysex_byte_o,
  output logic      [6:0]     sysex_length_o,
  output logic                last_o
);

  localparam int unsigned AW = $clog2(SYSEX_DEPTH);
  localparam int unsigned CW = $clog2(SYSEX_DEPTH + 1);

  // captured packet
  logic [3:0] code_q;
  logic [7:0] status_q, d1_q, d2_q;

  // frame state
  logic [CW-1:0] frame_count_q;
  logic          frame_active_q, frame_overflow_q;
  logic          first_f0_q;
  logic [7:0]    last_byte_q;
  logic [1:0]    byte_idx_q;
  logic [CW-1:0] len_q;
  logic [AW-1:0] rd_idx_q;

  // output register
  logic        out_valid_q;
  logic [2:0]  kind_q;
  logic [3:0]  chan_q;
  logic [6:0]  first_q, second_q;
  logic [13:0] bend_q;
  logic [7:0]  rt_q, sxb_q;
  logic [6:0]  sxlen_q;
  logic        last_q;

  // decode of the captured packet as a single result
  umpd_pkg::kind_e dec_kind;
  logic [3:0]  dec_chan;
  logic [6:0]  dec_first, dec_second;
  logic [13:0] dec_bend;
  logic [7:0]  dec_rt;
  logic [1:0]  nbytes_m1;
  logic        is_rt;
  logic [7:0]  app_byte;
  logic        room;
  logic [7:0]  rd_data;
  logic        emit_last;
  logic        out_free;
  logic [6:0]  d1_7, d2_7;

  assign is_rt = status_q >= umpd_pkg::BYTE_REALTIME;
  assign d1_7  = 7'(d1_q & umpd_pkg::DATA_MASK);
  assign d2_7  = 7'(d2_q & umpd_pkg::DATA_MASK);

  always_comb begin
    dec_kind   = umpd_pkg::KIND_ACTIVITY;
    dec_chan   = '0;
    dec_first  = '0;
    dec_second = '0;
    dec_bend   = '0;
    dec_rt     = '0;
    unique case (code_q)
      umpd_pkg::CIN_NOTE_OFF, umpd_pkg::CIN_NOTE_ON, umpd_pkg::CIN_CONTROL: begin
        dec_kind   = (code_q == umpd_pkg::CIN_NOTE_OFF) ? umpd_pkg::KIND_NOTE_OFF :
                     (code_q == umpd_pkg::CIN_NOTE_ON)  ? umpd_pkg::KIND_NOTE_ON  :
                                                          umpd_pkg::KIND_CONTROL;
        dec_chan   = status_q[3:0] & umpd_pkg::CHAN_MASK;
        dec_first  = d1_7;
        dec_second = d2_7;
      end
      umpd_pkg::CIN_PROGRAM: begin
        dec_kind  = umpd_pkg::KIND_PROGRAM;
        dec_chan  = status_q[3:0] & umpd_pkg::CHAN_MASK;
        dec_first = d1_7;
      end
      umpd_pkg::CIN_BEND: begin
        dec_kind = umpd_pkg::KIND_BEND;
        dec_chan = status_q[3:0] & umpd_pkg::CHAN_MASK;
        dec_bend = {d2_7, d1_7};
      end
      umpd_pkg::CIN_SINGLE, umpd_pkg::CIN_SYSEX_END1: begin
        if (is_rt) begin
          dec_kind = umpd_pkg::KIND_REALTIME;
          dec_rt   = status_q;
        end
      end
      default: begin
        dec_kind = umpd_pkg::KIND_ACTIVITY;
      end
    endcase
  end

  always_comb begin
    unique case (code_q)
      umpd_pkg::CIN_SYSEX_END1: nbytes_m1 = 2'd0;
      umpd_pkg::CIN_SYSEX_END2: nbytes_m1 = 2'd1;
      default:                  nbytes_m1 = 2'd2;
    endcase
  end

  always_comb begin
    unique case (byte_idx_q)
      2'd0:    app_byte = status_q;
      2'd1:    app_byte = d1_q;
      default: app_byte = d2_q;
    endcase
  end

  assign room      = frame_count_q < CW'(SYSEX_DEPTH);
  assign emit_last = (CW'(rd_idx_q) + CW'(1)) == len_q;
  assign out_free  = !out_valid_q || out_ready_i;

  assign sts_o.is_sysex    = (code_q == umpd_pkg::CIN_SYSEX_CONT) ||
                             (code_q == umpd_pkg::CIN_SYSEX_END2) ||
                             (code_q == umpd_pkg::CIN_SYSEX_END3) ||
                             ((code_q == umpd_pkg::CIN_SYSEX_END1) && !is_rt);
  assign sts_o.closing     = (code_q == umpd_pkg::CIN_SYSEX_END1) ||
                             (code_q == umpd_pkg::CIN_SYSEX_END2) ||
                             (code_q == umpd_pkg::CIN_SYSEX_END3);
  assign sts_o.append_last = byte_idx_q == nbytes_m1;
  assign sts_o.emit_ok     = frame_active_q && !frame_overflow_q &&
                             (frame_count_q >= CW'(2)) && first_f0_q &&
                             (last_byte_q == umpd_pkg::BYTE_SYSEX_END);
  assign sts_o.emit_last   = emit_last;
  assign sts_o.out_free    = out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      code_q   <= code_index_i;
      status_q <= status_byte_i;
      d1_q     <= data_one_i;
      d2_q     <= data_two_i;
    end
    if (cmd_i.append && frame_active_q && room) begin
      last_byte_q <= app_byte;
      if (frame_count_q == '0) begin
        first_f0_q <= app_byte == umpd_pkg::BYTE_SYSEX_START;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q    <= '0;
      frame_active_q   <= 1'b0;
      frame_overflow_q <= 1'b0;
      byte_idx_q       <= '0;
      len_q            <= '0;
      rd_idx_q         <= '0;
    end else begin
      if (cmd_i.capture) begin
        byte_idx_q <= '0;
      end
      if (cmd_i.begin_frame) begin
        if (status_q == umpd_pkg::BYTE_SYSEX_START) begin
          frame_count_q    <= '0;
          frame_active_q   <= 1'b1;
          frame_overflow_q <= 1'b0;
        end
      end else if (cmd_i.append) begin
        byte_idx_q <= byte_idx_q + 2'd1;
        if (frame_active_q) begin
          if (room) begin
            frame_count_q <= frame_count_q + CW'(1);
          end else begin
            frame_overflow_q <= 1'b1;
          end
        end
      end else if (cmd_i.close_frame) begin
        len_q            <= frame_count_q;
        rd_idx_q         <= '0;
        frame_count_q    <= '0;
        frame_active_q   <= 1'b0;
        frame_overflow_q <= 1'b0;
      end
      if (cmd_i.load && (cmd_i.load_sel == umpd_pkg::LOAD_SYSEX)) begin
        rd_idx_q <= rd_idx_q + AW'(1);
      end
    end
  end

  umpd_ram #(
    .WIDTH(8),
    .DEPTH(SYSEX_DEPTH)
  ) u_frame_store (
    .clk_i    (clk_i),
    .wr_en_i  (cmd_i.append && frame_active_q && room),
    .wr_addr_i(frame_count_q[AW-1:0]),
    .wr_data_i(app_byte),
    .rd_en_i  (cmd_i.rd_req),
    .rd_addr_i(rd_idx_q),
    .rd_data_o(rd_data)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      unique case (cmd_i.load_sel)
        umpd_pkg::LOAD_SINGLE: begin
          kind_q   <= dec_kind;
          chan_q   <= dec_chan;
          first_q  <= dec_first;
          second_q <= dec_second;
          bend_q   <= dec_bend;
          rt_q     <= dec_rt;
          sxb_q    <= '0;
          sxlen_q  <= '0;
          last_q   <= 1'b1;
        end
        umpd_pkg::LOAD_SYSEX: begin
          kind_q   <= umpd_pkg::KIND_SYSEX;
          chan_q   <= '0;
          first_q  <= '0;
          second_q <= '0;
          bend_q   <= '0;
          rt_q     <= '0;
          sxb_q    <= rd_data;
          sxlen_q  <= 7'(len_q);
          last_q   <= emit_last;
        end
        default: begin
          kind_q <= umpd_pkg::KIND_ACTIVITY;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = kind_q;
  assign channel_o       = chan_q;
  assign first_value_o   = first_q;
  assign second_value_o  = second_q;
  assign bend_amount_o   = bend_q;
  assign realtime_byte_o = rt_q;
  assign sysex_byte_o    = sxb_q;
  assign sysex_length_o  = sxlen_q;
  assign last_o          = last_q;

  `UMPD_ASSERT_IMPL(a_count_bound, 1'b1, frame_count_q <= CW'(SYSEX_DEPTH))
  `UMPD_ASSERT_IMPL(a_idle_frame_empty, !frame_active_q, frame_count_q == '0)
  `UMPD_ASSERT_IMPL(a_no_overwrite, cmd_i.load, out_free)
  `UMPD_ASSERT_IMPL(a_emit_len, cmd_i.load && cmd_i.load_sel == umpd_pkg::LOAD_SYSEX, len_q >= CW'(2))

endmodule

`default_nettype wire

// ===== rtl/core/umpd_ctrl.sv =====
// controller state machine sequencing decode, sysex append, close and readout
// depends on umpd_pkg and the assertion macro header
`default_nettype none
`include "usb_midi_packet_decoder_assert.svh"

module umpd_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire umpd_pkg::sts_t sts_i,
  output umpd_pkg::cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_APPEND = 7'b0000100,
    S_CLOSE  = 7'b0001000,
    S_REPLY  = 7'b0010000,
    S_READ   = 7'b0100000,
    S_SEND   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.load_sel = umpd_pkg::LOAD_SINGLE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_sysex) begin
          cmd_o.begin_frame = 1'b1;
          state_d           = S_APPEND;
        end else begin
          state_d = S_REPLY;
        end
      end
      S_APPEND: begin
        cmd_o.append = 1'b1;
        if (sts_i.append_last) begin
          state_d = sts_i.closing ? S_CLOSE : S_REPLY;
        end
      end
      S_CLOSE: begin
        cmd_o.close_frame = 1'b1;
        state_d           = sts_i.emit_ok ? S_READ : S_REPLY;
      end
      S_REPLY: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_READ: begin
        cmd_o.rd_req = 1'b1;
        state_d      = S_SEND;
      end
      S_SEND: begin
        cmd_o.load_sel = umpd_pkg::LOAD_SYSEX;
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.emit_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `UMPD_ASSERT_NEXT(a_accept_decodes, in_valid_i && in_ready_o, state_q == S_DECODE)

endmodule

`default_nettype wire

// ===== rtl/core/usb_midi_packet_decoder.sv =====
// usb-midi event packet decoder, top level
// depends on umpd_pkg, umpd_ctrl, umpd_dp (and through it umpd_ram)
//
// input channel: one four-byte usb-midi event packet per transaction
//   (code index, status byte, two data bytes; the cable number is not used)
// output channel: one decoded result per transaction; last_o marks the final
//   result that a packet causes
// channel, program, bend, realtime and plain sysex-data packets give one result
// a sysex end packet that closes a good frame gives one result per frame byte
// a channel or realtime packet passes the capture, decode and reply states
//   before its result shows; a sysex packet also passes the append state for
//   its bytes and, when it closes the frame, the close state
// frame readout alternates the read and send states for each byte, set by the
//   registered read of the frame store ram
// the input is taken only while the sequencer is idle, so a stalled receiver
//   holds the decoder once the next result is ready, but a finished result
//   waiting in the output register does not block the next input transaction
// reset clears the sequencer, the frame count and the active/overflow flags;
//   the frame store is not cleared, only written entries are ever read
`default_nettype none

module usb_midi_packet_decoder #(
  parameter int unsigned SYSEX_DEPTH = umpd_pkg::SYSEX_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // packet input
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [3:0]  code_index_i,
  input  wire logic [7:0]  status_byte_i,
  input  wire logic [7:0]  data_one_i,
  input  wire logic [7:0]  data_two_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [2:0]  event_kind_o,
  output logic      [3:0]  channel_o,
  output logic      [6:0]  first_value_o,
  output logic      [6:0]  second_value_o,
  output logic      [13:0] bend_amount_o,
  output logic      [7:0]  realtime_byte_o,
  output logic      [7:0]  sysex_byte_o,
  output logic      [6:0]  sysex_length_o,
  output logic             last_o
);

  // commands from the sequencer and status back from the datapath
  umpd_pkg::cmd_t cmd;
  umpd_pkg::sts_t sts;

  umpd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // datapath holds the captured packet, the frame store and the output register
  umpd_dp #(
    .SYSEX_DEPTH(SYSEX_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .code_index_i   (code_index_i),
    .status_byte_i  (status_byte_i),
    .data_one_i     (data_one_i),
    .data_two_i     (data_two_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_kind_o   (event_kind_o),
    .channel_o      (channel_o),
    .first_value_o  (first_value_o),
    .second_value_o (second_value_o),
    .bend_amount_o  (bend_amount_o),
    .realtime_byte_o(realtime_byte_o),
    .sysex_byte_o   (sysex_byte_o),
    .sysex_length_o (sysex_length_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire
